// ===== hdl/polynomial_newton_root_finder_assert.svh =====
// Assertion macros for the polynomial root finder.
`ifndef POLYNOMIAL_NEWTON_ROOT_FINDER_ASSERT_SVH
`define POLYNOMIAL_NEWTON_ROOT_FINDER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PNR_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define PNR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

// ===== hdl/pnrf_pkg.sv =====
package pnrf_pkg;
   localparam int FRAC_BITS = 24;
   localparam int QW = 24 + FRAC_BITS;
   localparam int COEF_W = 5;
   localparam int DEG_W = 3;
   localparam int CSR_W = 5;
   localparam int ROOT_W = 32;
   localparam int STAT_W = 2;
   localparam int ITER_W = 7;

   localparam logic [DEG_W-1:0] CSR_DEGREE = 3'd0;
   localparam logic [DEG_W-1:0] CSR_COEF_0 = 3'd1;
   localparam logic [DEG_W-1:0] CSR_COEF_4 = 3'd5;

   localparam logic [STAT_W-1:0] ST_ZERO_STEP = 2'd0;
   localparam logic [STAT_W-1:0] ST_ZERO_DERIV = 2'd1;
   localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;

   typedef logic [QW-1:0] q_type;

   typedef struct packed {
      logic          start;
      logic          is_div;
      logic [QW-1:0] a;
      logic [QW-1:0] b;
   } op_req_type;

   typedef struct packed {
      logic          done;
      logic [QW-1:0] result;
   } op_rsp_type;
endpackage

// ===== hdl/pnrf_req_if.sv =====
interface pnrf_req_if;
   logic valid;
   logic ready;
   logic start_req;
   modport source (output valid, output start_req, input ready);
   modport sink (input valid, input start_req, output ready);
endinterface

// ===== hdl/pnrf_rsp_if.sv =====
interface pnrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] root;
   logic [1:0]  status;
   logic [6:0]  iterations;
   modport source (output valid, output root, output status, output iterations, input ready);
   modport sink (input valid, input root, input status, input iterations, output ready);
endinterface

// ===== hdl/pnrf_muldiv.sv =====
module pnrf_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  pnrf_pkg::op_req_type op_req,
   output pnrf_pkg::op_rsp_type op_rsp
);
   import pnrf_pkg::*;

   // Shared unit: Q fixed-point multiply (16 bits a cycle) or restoring divide
   // (one quotient bit a cycle) on magnitudes, then sign and saturation.
   localparam int W = QW;
   localparam int PW = 2 * W;
   localparam int DN = W + FRAC_BITS;
   localparam int CW = $clog2(DN + 2);
   localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W:0] LIMP = {2'b00, {(W-1){1'b1}}};
   localparam logic [W:0] LIMN = {2'b01, {(W-1){1'b0}}};
   localparam int MCH = 16;
   localparam int MSTEPS = W / MCH;

   logic          busy_ff, busy_in;
   logic          div_ff, div_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  ma_ff, ma_in;
   logic [W-1:0]  mb_ff, mb_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [W:0]    rem_ff, rem_in;
   logic [DN-1:0] num_ff, num_in;
   logic [DN-1:0] quo_ff, quo_in;
   logic          done_ff, done_in;
   logic [W-1:0]  res_ff, res_in;

   logic [W-1:0]    abs_a, abs_b;
   logic [W:0]      rsh;
   logic [W+MCH-1:0] part;
   logic [PW-1:0]   pshift;
   logic [W:0]      mag;
   logic            ovf;

   always_comb begin
      abs_a = op_req.a[W-1] ? W'(-op_req.a) : op_req.a;
      abs_b = op_req.b[W-1] ? W'(-op_req.b) : op_req.b;
      rsh = {rem_ff[W-1:0], num_ff[DN-1]};
      part = ma_ff * mb_ff[MCH-1:0];
      pshift = PW'(part) << (MCH * (int'(cnt_ff)));
      ovf = 1'b0;
      mag = '0;
      if (div_ff) begin
         ovf = |quo_ff[DN-1:W];
         mag = {1'b0, quo_ff[W-1:0]};
      end else begin
         ovf = |acc_ff[PW-1:W+FRAC_BITS];
         mag = {1'b0, acc_ff[W+FRAC_BITS-1:FRAC_BITS]};
      end
      busy_in = busy_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      done_in = 1'b0;
      res_in = res_ff;
      if (!busy_ff) begin
         if (op_req.start) begin
            busy_in = 1'b1;
            div_in = op_req.is_div;
            neg_in = op_req.a[W-1] ^ op_req.b[W-1];
            cnt_in = '0;
            ma_in = abs_a;
            mb_in = abs_b;
            acc_in = '0;
            rem_in = '0;
            num_in = {abs_a, {FRAC_BITS{1'b0}}};
            quo_in = '0;
         end
      end else if (div_ff) begin
         if (cnt_ff == CW'(DN)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            num_in = num_ff << 1;
            if (rsh >= {1'b0, mb_ff}) begin
               rem_in = rsh - {1'b0, mb_ff};
               quo_in = {quo_ff[DN-2:0], 1'b1};
            end else begin
               rem_in = rsh;
               quo_in = {quo_ff[DN-2:0], 1'b0};
            end
         end
      end else begin
         if (cnt_ff == CW'(MSTEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            acc_in = acc_ff + pshift;
            mb_in = mb_ff >> MCH;
         end
      end
      if (done_in) begin
         if (neg_ff) begin
            res_in = (ovf || mag > LIMN) ? W'(LIMN) : W'(-mag);
         end else begin
            res_in = (ovf || mag > LIMP) ? QMAX : mag[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign op_rsp.done = done_ff;
   assign op_rsp.result = res_ff;
endmodule

// ===== hdl/polynomial_newton_root_finder.sv =====
// Channel   Dir  Signals
// req       in   valid, ready, start_req
// rsp       out  valid, ready, root, status, iterations
// csr       in   csr_write, csr_index, csr_data
// One search takes up to MAX_ITERATIONS iterations; each runs up to 2*MAX_DEGREE-1
// multiplies and one division in the shared unit, plus the sequencer states.
// A request with start_req low is accepted and gives no response.
// Reset is synchronous and clears the degree and coefficient registers and the sequencer.
// While a search runs or a response waits, req.ready stays low.
module polynomial_newton_root_finder #(
   parameter int MAX_DEGREE = 4,
   parameter int MAX_ITERATIONS = 100
) (
   input  logic                         clock,
   input  logic                         reset,
   pnrf_req_if.sink                     req,
   pnrf_rsp_if.source                   rsp,
   input  logic                         csr_write,
   input  logic [pnrf_pkg::DEG_W-1:0]   csr_index,
   input  logic [pnrf_pkg::CSR_W-1:0]   csr_data
);
   import pnrf_pkg::*;
`include "polynomial_newton_root_finder_assert.svh"

   localparam int W = QW;
   localparam int NC = 5;
   localparam int IW = $clog2(MAX_ITERATIONS + 1);
   localparam int DGW = $clog2(MAX_DEGREE + 1);
   localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DINIT = 4'd1;
   localparam logic [3:0] S_DMUL = 4'd2;
   localparam logic [3:0] S_DWAIT = 4'd3;
   localparam logic [3:0] S_PINIT = 4'd4;
   localparam logic [3:0] S_PMUL = 4'd5;
   localparam logic [3:0] S_PWAIT = 4'd6;
   localparam logic [3:0] S_DIV = 4'd7;
   localparam logic [3:0] S_DIVW = 4'd8;
   localparam logic [3:0] S_FIN = 4'd9;
   localparam logic [3:0] S_OUT = 4'd10;

   logic [DEG_W-1:0]  degree_ff;
   logic [COEF_W-1:0] coef_ff [NC];
   logic [3:0]        state_ff, state_in;
   logic [W-1:0]      x_ff, x_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic [W-1:0]      d_ff, d_in;
   logic [DGW-1:0]    deg_ff, deg_in;
   logic [DGW-1:0]    k_ff, k_in;
   logic [IW-1:0]     it_ff, it_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   op_req_type        op_req;
   op_rsp_type        op_rsp;

   logic [W-1:0]   cterm, dterm, sum, diffx;
   logic [W+1:0]   sumw, diffw;
   logic [W-1:0]   absx;
   logic [W-FRAC_BITS+16-1:0] mr;

   // Coefficient i as Q value (unused above coef_4), and i*coef_i saturated.
   function automatic logic [W-1:0] coef_q(input logic [DGW-1:0] i,
                                           input logic [DGW:0] mulby);
      logic signed [COEF_W+DGW+1:0] c;
      logic signed [W+1:0] v;
      begin
         c = '0;
         if (int'(i) < NC) c = (COEF_W+DGW+2)'(signed'(coef_ff[i]));
         c = c * signed'({1'b0, mulby});
         v = (W+2)'(c) <<< FRAC_BITS;
         if (v > signed'({2'b00, QMAX})) coef_q = QMAX;
         else if (v < signed'({2'b11, QMIN})) coef_q = QMIN;
         else coef_q = v[W-1:0];
      end
   endfunction

   function automatic logic [W-1:0] sat_add(input logic [W+1:0] s);
      begin
         if (signed'(s) > signed'({2'b00, QMAX})) sat_add = QMAX;
         else if (signed'(s) < signed'({2'b11, QMIN})) sat_add = QMIN;
         else sat_add = s[W-1:0];
      end
   endfunction

   pnrf_muldiv u_unit (
      .clock  (clock),
      .reset  (reset),
      .op_req (op_req),
      .op_rsp (op_rsp)
   );

   always_comb begin
      cterm = coef_q(k_ff, (DGW+1)'(1));
      dterm = coef_q(k_ff, {1'b0, k_ff});
      sumw = {{2{op_rsp.result[W-1]}}, op_rsp.result}
         + {{2{(state_ff == S_PWAIT) ? cterm[W-1] : dterm[W-1]}},
            (state_ff == S_PWAIT) ? cterm : dterm};
      sum = sat_add(sumw);
      diffw = {{2{x_ff[W-1]}}, x_ff} - {{2{op_rsp.result[W-1]}}, op_rsp.result};
      diffx = sat_add(diffw);
      absx = x_ff[W-1] ? W'(-x_ff) : x_ff;
      mr = absx[W-1:FRAC_BITS-16];
      root_in = root_ff;
      if (x_ff[W-1]) begin
         root_in = (mr > (W-FRAC_BITS+16)'(33'h080000000)) ? 32'h80000000
            : ROOT_W'(-mr);
      end else begin
         root_in = (mr > (W-FRAC_BITS+16)'(32'h7fffffff)) ? 32'h7fffffff
            : mr[ROOT_W-1:0];
      end

      state_in = state_ff;
      x_in = x_ff;
      acc_in = acc_ff;
      d_in = d_ff;
      deg_in = deg_ff;
      k_in = k_ff;
      it_in = it_ff;
      stat_in = stat_ff;
      op_req = '0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               deg_in = (int'(degree_ff) > MAX_DEGREE) ? DGW'(MAX_DEGREE)
                  : DGW'(degree_ff);
               x_in = '0;
               it_in = '0;
               state_in = req.start_req ? S_DINIT : S_IDLE;
            end
         end
         S_DINIT: begin
            if (deg_ff == '0) begin
               stat_in = ST_ZERO_DERIV;
               state_in = S_FIN;
            end else begin
               acc_in = coef_q(deg_ff, {1'b0, deg_ff});
               k_in = deg_ff - 1'b1;
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            if (k_ff == '0) begin
               d_in = acc_ff;
               if (acc_ff == '0) begin
                  stat_in = ST_ZERO_DERIV;
                  state_in = S_FIN;
               end else begin
                  state_in = S_PINIT;
               end
            end else begin
               op_req.start = 1'b1;
               op_req.a = acc_ff;
               op_req.b = x_ff;
               state_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (op_rsp.done) begin
               acc_in = sum;
               k_in = k_ff - 1'b1;
               state_in = S_DMUL;
            end
         end
         S_PINIT: begin
            acc_in = coef_q(deg_ff, (DGW+1)'(1));
            k_in = deg_ff;
            state_in = S_PMUL;
         end
         S_PMUL: begin
            if (k_ff == '0) begin
               state_in = S_DIV;
            end else begin
               op_req.start = 1'b1;
               op_req.a = acc_ff;
               op_req.b = x_ff;
               k_in = k_ff - 1'b1;
               state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            if (op_rsp.done) begin
               acc_in = sum;
               state_in = S_PMUL;
            end
         end
         S_DIV: begin
            op_req.start = 1'b1;
            op_req.is_div = 1'b1;
            op_req.a = acc_ff;
            op_req.b = d_ff;
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (op_rsp.done) begin
               x_in = diffx;
               it_in = it_ff + 1'b1;
               if (diffx == x_ff) begin
                  stat_in = ST_ZERO_STEP;
                  state_in = S_FIN;
               end else if (it_ff == IW'(MAX_ITERATIONS - 1)) begin
                  stat_in = ST_LIMIT;
                  state_in = S_FIN;
               end else begin
                  state_in = S_DINIT;
               end
            end
         end
         S_FIN: state_in = S_OUT;
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         degree_ff <= '0;
         for (int i = 0; i < NC; i++) coef_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            if (csr_index == CSR_DEGREE) begin
               degree_ff <= csr_data[DEG_W-1:0];
            end else if (csr_index >= CSR_COEF_0 && csr_index <= CSR_COEF_4) begin
               coef_ff[csr_index - CSR_COEF_0] <= csr_data;
            end
         end
      end
      x_ff <= x_in;
      acc_ff <= acc_in;
      d_ff <= d_in;
      deg_ff <= deg_in;
      k_ff <= k_in;
      it_ff <= it_in;
      stat_ff <= stat_in;
      if (state_ff == S_FIN) root_ff <= root_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.root = root_ff;
   assign rsp.status = stat_ff;
   assign rsp.iterations = ITER_W'(it_ff);

   `PNR_ASSERT_IMPLY(a_no_overlap, clock, reset, rsp.valid, !req.ready, "ready while response pending")
   `PNR_ASSERT_IMPLY(a_iter_limit, clock, reset, rsp.valid, it_ff <= IW'(MAX_ITERATIONS), "iteration count beyond limit")
   `PNR_ASSERT_NEXT(a_done_idle, clock, reset, op_rsp.done, !op_rsp.done, "unit done held two cycles")
endmodule
